// ===== rtl/fmc_pkg.sv =====
// Shared types and constants for the flashlight mode controller.
// No dependencies; compile first.
package fmc_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 10;
	localparam int unsigned HELD_W     = 10;
	localparam int unsigned FLASH_W    = 8;
	localparam int unsigned NIB_W      = 4;

	localparam logic [HELD_W-1:0] HELD_MAX = '1;

	// register indexes on the configuration channel
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOOP_TICKS  = 3'd0,
		CFG_HALF_HIGH   = 3'd1,
		CFG_LOW_HIGH    = 3'd2,
		CFG_DEBOUNCE    = 3'd3,
		CFG_LONG_PRESS  = 3'd4,
		CFG_FLASH_HALF  = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		MODE_OFF    = 3'd0,
		MODE_STEADY = 3'd1,
		MODE_HALF   = 3'd2,
		MODE_LOW    = 3'd3,
		MODE_FLASH  = 3'd4
	} mode_t;

	typedef struct packed {
		logic [NIB_W-1:0]   loop_ticks;
		logic [NIB_W-1:0]   half_duty_high_ticks;
		logic [NIB_W-1:0]   low_duty_high_ticks;
		logic [NIB_W-1:0]   debounce_loops;
		logic [HELD_W-1:0]  long_press_loops;
		logic [FLASH_W-1:0] flash_half_loops;
	} cfg_t;

	typedef struct packed {
		logic  led_on;
		mode_t mode;
		logic  button_stable;
	} result_t;

endpackage

// ===== rtl/fmc_ifs.sv =====
// Handshake channel interfaces: tick in, result out, register writes.
// Depends on fmc_pkg.
interface fmc_tick_if;
	logic valid;
	logic ready;
	logic raw_button;
	modport source(output valid, output raw_button, input ready);
	modport sink(input valid, input raw_button, output ready);
endinterface

interface fmc_result_if;
	logic       valid;
	logic       ready;
	logic       led_on;
	logic [2:0] mode;
	logic       button_stable;
	modport source(output valid, output led_on, output mode, output button_stable,
		input ready);
	modport sink(input valid, input led_on, input mode, input button_stable,
		output ready);
endinterface

interface fmc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [fmc_pkg::CFG_IDX_W-1:0]  index;
	logic [fmc_pkg::CFG_DATA_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ===== rtl/fmc_cfg_regs.sv =====
// Configuration register file, written one register per item.
// Depends on fmc_pkg.
module fmc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [fmc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [fmc_pkg::CFG_DATA_W-1:0] wr_data,
	output fmc_pkg::cfg_t                 cfg
);
	import fmc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.loop_ticks           <= 4'd10;
			cfg_q.half_duty_high_ticks <= 4'd5;
			cfg_q.low_duty_high_ticks  <= 4'd1;
			cfg_q.debounce_loops       <= 4'd3;
			cfg_q.long_press_loops     <= 10'd100;
			cfg_q.flash_half_loops     <= 8'd50;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				CFG_LOOP_TICKS: cfg_q.loop_ticks           <= wr_data[NIB_W-1:0];
				CFG_HALF_HIGH:  cfg_q.half_duty_high_ticks <= wr_data[NIB_W-1:0];
				CFG_LOW_HIGH:   cfg_q.low_duty_high_ticks  <= wr_data[NIB_W-1:0];
				CFG_DEBOUNCE:   cfg_q.debounce_loops       <= wr_data[NIB_W-1:0];
				CFG_LONG_PRESS: cfg_q.long_press_loops     <= wr_data[HELD_W-1:0];
				CFG_FLASH_HALF: cfg_q.flash_half_loops     <= wr_data[FLASH_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/fmc_core.sv =====
// Controller state and per-tick update: debounce, hold count, mode, LED.
// Depends on fmc_pkg.
module fmc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              raw_button,
	input  fmc_pkg::cfg_t     cfg,
	output fmc_pkg::result_t  result
);
	import fmc_pkg::*;

	logic [NIB_W-1:0]   tick_q, tick_n;
	logic               last_q, last_n;
	logic [NIB_W-1:0]   same_q, same_n;
	logic               stable_q, stable_n;
	logic               held_flag_q, held_flag_n;
	logic [HELD_W-1:0]  held_q, held_n;
	mode_t              mode_q, mode_n;
	logic [FLASH_W-1:0] flash_q, flash_n;
	logic               led_q, led_n;
	logic [NIB_W-1:0]   tick_inc;

	always_comb begin
		last_n      = last_q;
		same_n      = same_q;
		stable_n    = stable_q;
		held_flag_n = held_flag_q;
		held_n      = held_q;
		mode_n      = mode_q;
		flash_n     = flash_q;
		led_n       = led_q;

		// loop work only on the first tick of a loop
		if (tick_q == '0) begin
			if (raw_button != last_q) begin
				last_n = raw_button;
				same_n = '0;
			end else begin
				if (same_q < cfg.debounce_loops)
					same_n = same_q + 4'd1;
				if (same_n >= cfg.debounce_loops)
					stable_n = last_q;
			end

			if (!stable_n) begin
				held_flag_n = 1'b1;
				if (!held_flag_q)
					held_n = '0;
				if (held_n != HELD_MAX)
					held_n = held_n + 10'd1;
			end else begin
				if (held_flag_q) begin
					if (held_q >= cfg.long_press_loops)
						mode_n = (mode_q == MODE_OFF) ? MODE_STEADY : MODE_OFF;
					else if (mode_q != MODE_OFF)
						mode_n = mode_t'({1'b0, mode_q[1:0]} + 3'd1);
					flash_n = '0;
				end
				held_flag_n = 1'b0;
			end

			if (mode_n == MODE_FLASH) begin
				flash_n = flash_n + 8'd1;
				if (flash_n >= cfg.flash_half_loops) begin
					flash_n = '0;
					led_n   = ~led_q;
				end
			end
		end

		case (mode_n)
			MODE_STEADY: led_n = 1'b1;
			MODE_HALF:   led_n = (tick_q < cfg.half_duty_high_ticks);
			MODE_LOW:    led_n = (tick_q < cfg.low_duty_high_ticks);
			MODE_FLASH:  led_n = led_n;
			default:     led_n = 1'b0;
		endcase

		// a shrunk loop length restarts the loop at once
		tick_inc = tick_q + 4'd1;
		tick_n   = (tick_inc >= cfg.loop_ticks) ? '0 : tick_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= '0;
			last_q      <= 1'b1;
			same_q      <= '0;
			stable_q    <= 1'b1;
			held_flag_q <= 1'b0;
			held_q      <= '0;
			mode_q      <= MODE_OFF;
			flash_q     <= '0;
			led_q       <= 1'b0;
		end else if (step) begin
			tick_q      <= tick_n;
			last_q      <= last_n;
			same_q      <= same_n;
			stable_q    <= stable_n;
			held_flag_q <= held_flag_n;
			held_q      <= held_n;
			mode_q      <= mode_n;
			flash_q     <= flash_n;
			led_q       <= led_n;
		end
	end

	assign result.led_on        = led_n;
	assign result.mode          = mode_n;
	assign result.button_stable = stable_n;

endmodule

// ===== rtl/flashlight_mode_controller.sv =====
// Top level of the flashlight mode controller: input register, core, result register.
// Depends on fmc_pkg, fmc_ifs, fmc_cfg_regs, fmc_core.
//
// Channel | Dir | Payload                            | Handshake
// --------+-----+------------------------------------+-------------
// tick    | in  | raw_button (1b, 0 = pressed)       | valid/ready
// result  | out | led_on, mode (3b), button_stable   | valid/ready
// cfg     | in  | index (3b), data (10b)             | valid/ready
//
// One tick item per clock cycle sustained while result.ready holds; a tick is
// taken into the input register, then its result into the result register.
// The per-tick update is one pass of combinational logic in fmc_core.
// Reset (arst_n low) loads the register defaults and resets control state but
// not raw_button_s1 or res_q; the block takes items from the first cycle after reset.
// A stalled result holds in the result register while one more tick waits in
// the input register; cfg is always ready.
module flashlight_mode_controller (
	input logic          clk,
	input logic          arst_n,
	fmc_tick_if.sink     tick,
	fmc_result_if.source result,
	fmc_cfg_if.sink      cfg
);
	import fmc_pkg::*;

	logic    in_valid_s1;
	logic    raw_button_s1;
	logic    out_valid_q;
	logic    advance;
	cfg_t    cfg_regs;
	result_t core_res;
	result_t res_q;

	assign cfg.ready = 1'b1;

	fmc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	// the held item moves on when the result slot is free or being emptied
	assign advance    = in_valid_s1 && (!out_valid_q || result.ready);
	assign tick.ready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			in_valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			raw_button_s1 <= tick.raw_button;
		end
	end

	fmc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.raw_button (raw_button_s1),
		.cfg        (cfg_regs),
		.result     (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= core_res;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.led_on        = res_q.led_on;
	assign result.mode          = res_q.mode;
	assign result.button_stable = res_q.button_stable;

endmodule
